>>> hw/rtl/ptwi_pkg.sv
// Shared constants, register codes and types for the windowed-integral PID turn core.
package ptwi_pkg;

    // Error ring (moving window of the integral term)
    localparam int RING_DEPTH = 250;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    // Result queue; depth must be a power of two so the pointers wrap by themselves
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int PEND_W     = $clog2(FIFO_DEPTH + 1);

    // Field and datapath widths
    localparam int LVL_W      = 7;
    localparam int GAIN_W     = 32;
    localparam int ERR_W      = 8;
    localparam int DIFF_W     = 9;
    localparam int SUM_W      = 16;
    localparam int TURN_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FRAC_BITS  = 24;
    localparam int P_W        = GAIN_W + 1 + ERR_W;
    localparam int I_W        = GAIN_W + 1 + SUM_W;
    localparam int D_W        = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W      = 50;
    localparam int QUO_W      = ACC_W - FRAC_BITS;

    // Reset values of the registers
    localparam logic [LVL_W-1:0]  RST_TARGET_LEVEL  = 7'd35;
    localparam logic [GAIN_W-1:0] RST_PROP_GAIN     = 32'd12415139;
    localparam logic [GAIN_W-1:0] RST_INTEG_GAIN_DT = 32'd671;
    localparam logic [GAIN_W-1:0] RST_DERIV_GAIN_DT = 32'd125829120;
    localparam logic [LVL_W-1:0]  RST_TURN_LIMIT    = 7'd100;
    localparam logic [LVL_W-1:0]  RST_CRUISE_SPEED  = 7'd45;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_LEVEL  = 3'd0,
        REG_PROP_GAIN     = 3'd1,
        REG_INTEG_GAIN_DT = 3'd2,
        REG_DERIV_GAIN_DT = 3'd3,
        REG_TURN_LIMIT    = 3'd4,
        REG_CRUISE_SPEED  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [LVL_W-1:0]  target_level;
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain_dt;
        logic [GAIN_W-1:0] deriv_gain_dt;
        logic [LVL_W-1:0]  turn_limit;
        logic [LVL_W-1:0]  cruise_speed;
    } t_cfg;

    typedef struct packed {
        logic                    en;
        logic signed [ERR_W-1:0] err;
    } t_ring_wr;

    typedef struct packed {
        logic [LVL_W-1:0]         forward_cmd;
        logic signed [TURN_W-1:0] turn_cmd;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_res_wr;

endpackage

>>> hw/rtl/ptwi_if.sv
// Valid/ready channel interfaces: sample input, command output, register writes.
interface ptwi_in_if;
    import ptwi_pkg::*;
    logic             valid;
    logic             ready;
    logic [LVL_W-1:0] brightness;
    logic             obstacle;
    modport source (output valid, output brightness, output obstacle, input ready);
    modport sink   (input valid, input brightness, input obstacle, output ready);
endinterface

interface ptwi_out_if;
    import ptwi_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [LVL_W-1:0]         forward_cmd;
    logic signed [TURN_W-1:0] turn_cmd;
    modport source (output valid, output forward_cmd, output turn_cmd, input ready);
    modport sink   (input valid, input forward_cmd, input turn_cmd, output ready);
endinterface

interface ptwi_cfg_if;
    import ptwi_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/ptwi_cfg.sv
// Configuration register file.
module ptwi_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [ptwi_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  logic [ptwi_pkg::CFG_DATA_W-1:0] i_wr_data,
    output ptwi_pkg::t_cfg                  o_cfg
);
    import ptwi_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_level  <= RST_TARGET_LEVEL;
            r_cfg.prop_gain     <= RST_PROP_GAIN;
            r_cfg.integ_gain_dt <= RST_INTEG_GAIN_DT;
            r_cfg.deriv_gain_dt <= RST_DERIV_GAIN_DT;
            r_cfg.turn_limit    <= RST_TURN_LIMIT;
            r_cfg.cruise_speed  <= RST_CRUISE_SPEED;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                REG_TARGET_LEVEL:  r_cfg.target_level  <= i_wr_data[LVL_W-1:0];
                REG_PROP_GAIN:     r_cfg.prop_gain     <= i_wr_data[GAIN_W-1:0];
                REG_INTEG_GAIN_DT: r_cfg.integ_gain_dt <= i_wr_data[GAIN_W-1:0];
                REG_DERIV_GAIN_DT: r_cfg.deriv_gain_dt <= i_wr_data[GAIN_W-1:0];
                REG_TURN_LIMIT:    r_cfg.turn_limit    <= i_wr_data[LVL_W-1:0];
                REG_CRUISE_SPEED:  r_cfg.cruise_speed  <= i_wr_data[LVL_W-1:0];
                default: ;  // unmapped index: dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/ptwi_ring.sv
// Error ring: window memory, write index and first-pass mask.
module ptwi_ring (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ptwi_pkg::t_ring_wr                 i_wr,
    output logic signed [ptwi_pkg::ERR_W-1:0]  o_old
);
    import ptwi_pkg::*;

    logic signed [ERR_W-1:0] r_mem [RING_DEPTH];
    logic [RING_AW-1:0]      r_idx;
    logic                    r_wrapped;
    logic signed [ERR_W-1:0] r_rd;
    logic                    r_rd_ok;

    // Read-first: the entry being overwritten is registered and comes out in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[r_idx] <= i_wr.err;
        end
        r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_wrapped <= 1'b0;
            r_rd_ok   <= 1'b0;
        end else begin
            r_rd_ok <= r_wrapped;
            if (i_wr.en) begin
                if (r_idx == RING_AW'(RING_DEPTH - 1)) begin
                    r_idx     <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_idx <= r_idx + RING_AW'(1);
                end
            end
        end
    end

    // slots not yet written since reset read as zero
    assign o_old = r_rd_ok ? r_rd : '0;

endmodule

>>> hw/rtl/ptwi_pipe.sv
// PID datapath: error, window sum, gain products, truncation and saturation.
module ptwi_pipe (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ptwi_pkg::t_cfg                    i_cfg,
    input  logic                              i_acc,
    input  logic [ptwi_pkg::LVL_W-1:0]        i_brightness,
    input  logic                              i_obstacle,
    input  logic signed [ptwi_pkg::ERR_W-1:0] i_old,
    output ptwi_pkg::t_ring_wr                o_ring_wr,
    output ptwi_pkg::t_res_wr                 o_res_wr
);
    import ptwi_pkg::*;

    // accept stage
    logic signed [ERR_W-1:0]  s0_err;
    logic signed [DIFF_W-1:0] s0_diff;
    logic signed [ERR_W-1:0]  r_prev;

    // stage 1: window sum
    logic                     r1_valid, r1_obst;
    logic signed [ERR_W-1:0]  r1_err;
    logic signed [DIFF_W-1:0] r1_diff;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  n_sum;

    // stage 2: products
    logic                     r2_valid, r2_obst;
    logic signed [ERR_W-1:0]  r2_err;
    logic signed [SUM_W-1:0]  r2_sum;
    logic signed [DIFF_W-1:0] r2_diff;
    logic signed [P_W-1:0]    n_p;
    logic signed [I_W-1:0]    n_i;
    logic signed [D_W-1:0]    n_d;

    // stage 3: accumulate
    logic                     r3_valid, r3_obst;
    logic signed [P_W-1:0]    r3_p;
    logic signed [I_W-1:0]    r3_i;
    logic signed [D_W-1:0]    r3_d;
    logic signed [ACC_W-1:0]  n_acc;

    // stage 4: scale and clamp
    logic                     r4_valid, r4_obst;
    logic signed [ACC_W-1:0]  r4_acc;
    logic signed [QUO_W-1:0]  q_floor, q_trunc, lim_pos, lim_neg;
    logic                     round_up;
    logic signed [TURN_W-1:0] turn;

    assign s0_err  = $signed({1'b0, i_brightness}) - $signed({1'b0, i_cfg.target_level});
    assign s0_diff = $signed({s0_err[ERR_W-1], s0_err}) - $signed({r_prev[ERR_W-1], r_prev});

    assign o_ring_wr.en  = i_acc && !i_obstacle;
    assign o_ring_wr.err = s0_err;

    assign n_sum = r_sum
                 - $signed({{(SUM_W-ERR_W){i_old[ERR_W-1]}}, i_old})
                 + $signed({{(SUM_W-ERR_W){r1_err[ERR_W-1]}}, r1_err});

    assign n_p = $signed({1'b0, i_cfg.prop_gain})     * r2_err;
    assign n_i = $signed({1'b0, i_cfg.integ_gain_dt}) * r2_sum;
    assign n_d = $signed({1'b0, i_cfg.deriv_gain_dt}) * r2_diff;

    assign n_acc = ACC_W'(r3_p) + ACC_W'(r3_i) + ACC_W'(r3_d);

    // divide by 2^24 rounding toward zero
    assign q_floor  = r4_acc[ACC_W-1:FRAC_BITS];
    assign round_up = r4_acc[ACC_W-1] && (|r4_acc[FRAC_BITS-1:0]);
    assign q_trunc  = q_floor + $signed({{(QUO_W-1){1'b0}}, round_up});
    assign lim_pos  = $signed({{(QUO_W-LVL_W){1'b0}}, i_cfg.turn_limit});
    assign lim_neg  = -lim_pos;

    always_comb begin
        priority if (r4_obst) begin
            turn = '0;
        end else if (q_trunc > lim_pos) begin
            turn = lim_pos[TURN_W-1:0];
        end else if (q_trunc < lim_neg) begin
            turn = lim_neg[TURN_W-1:0];
        end else begin
            turn = q_trunc[TURN_W-1:0];
        end
    end

    assign o_res_wr.valid           = r4_valid;
    assign o_res_wr.res.forward_cmd = r4_obst ? '0 : i_cfg.cruise_speed;
    assign o_res_wr.res.turn_cmd    = turn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r_prev   <= '0;
            r_sum    <= '0;
        end else begin
            r1_valid <= i_acc;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            if (i_acc && !i_obstacle) begin
                r_prev <= s0_err;
            end
            if (r1_valid && !r1_obst) begin
                r_sum <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r1_obst <= i_obstacle;
        r1_err  <= s0_err;
        r1_diff <= s0_diff;
        r2_obst <= r1_obst;
        r2_err  <= r1_err;
        r2_sum  <= n_sum;
        r2_diff <= r1_diff;
        r3_obst <= r2_obst;
        r3_p    <= n_p;
        r3_i    <= n_i;
        r3_d    <= n_d;
        r4_obst <= r3_obst;
        r4_acc  <= n_acc;
    end

endmodule

>>> hw/rtl/ptwi_fifo.sv
// Result queue between the datapath and the output channel.
module ptwi_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptwi_pkg::t_res_wr i_wr,
    input  logic              i_pop,
    output ptwi_pkg::t_result o_head,
    output logic              o_valid
);
    import ptwi_pkg::*;

    t_result             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wptr, r_rptr;
    logic [PEND_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_wr.valid) begin
            r_mem[r_wptr] <= i_wr.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr.valid) begin
                r_wptr <= r_wptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + FIFO_AW'(1);
            end
            r_count <= r_count + PEND_W'(i_wr.valid) - PEND_W'(i_pop);
        end
    end

    assign o_head  = r_mem[r_rptr];
    assign o_valid = (r_count != '0);

endmodule

>>> hw/rtl/pid_turn_windowed_integral_core.sv
// Top level of the windowed-integral PID steering core.
//
// Line-following PID steering controller. Each input beat carries a brightness
// sample and an obstacle flag; each one yields exactly one output beat with a
// forward command and a saturated turn command. The integral term is the sum of
// the last 250 errors, kept in a ring memory that is read at the same edge the
// new error overwrites the slot (read-first), so the old entry arrives in the
// next cycle. Throughput is one beat per clock while input ready is high: the
// datapath is a fixed five-stage pipeline (error, window sum, gain products,
// three-way add, scale and clamp) that never stalls, so a result is written into
// the 8-entry output queue from the scale-and-clamp stage and can leave on the
// following edge. Input ready drops only when 8 beats are outstanding (in the
// pipeline or waiting in the queue), so a slow consumer throttles the input
// without any combinational path from output ready to input ready. There is no
// clearing pass after reset: ring slots not yet written in the first trip around
// the window read as zero. Obstacle beats give zero outputs and leave the
// controller state untouched. Register writes are always accepted outside reset
// and must only be issued while no beat is in flight.
module pid_turn_windowed_integral_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ptwi_in_if.sink    i_in,
    ptwi_out_if.source o_out,
    ptwi_cfg_if.sink   i_cfg
);
    import ptwi_pkg::*;

    t_cfg                    w_cfg;
    t_ring_wr                w_ring_wr;
    t_res_wr                 w_res_wr;
    t_result                 w_head;
    logic signed [ERR_W-1:0] w_old;
    logic                    w_head_valid;
    logic                    in_acc, out_pop;
    logic [PEND_W-1:0]       r_pending;

    // credit count: beats accepted and not yet delivered
    assign in_acc      = i_in.valid && i_in.ready;
    assign out_pop     = o_out.valid && o_out.ready;
    assign i_in.ready  = i_rst_n && (r_pending < PEND_W'(FIFO_DEPTH));
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + PEND_W'(in_acc) - PEND_W'(out_pop);
        end
    end

    ptwi_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid && i_cfg.ready),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (w_cfg)
    );

    ptwi_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_ring_wr),
        .o_old   (w_old)
    );

    ptwi_pipe u_pipe (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_acc        (in_acc),
        .i_brightness (i_in.brightness),
        .i_obstacle   (i_in.obstacle),
        .i_old        (w_old),
        .o_ring_wr    (w_ring_wr),
        .o_res_wr     (w_res_wr)
    );

    ptwi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_wr),
        .i_pop   (out_pop),
        .o_head  (w_head),
        .o_valid (w_head_valid)
    );

    assign o_out.valid       = w_head_valid;
    assign o_out.forward_cmd = w_head.forward_cmd;
    assign o_out.turn_cmd    = w_head.turn_cmd;

    // credits bound the queue, so the count never passes its depth
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= PEND_W'(FIFO_DEPTH))
        else $error("outstanding beat count above queue depth");

    // a queued result always has a matching credit
    a_out_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_pending != '0))
        else $error("output beat without an outstanding input beat");

    // obstacle beat comes out of the pipe as an all-zero result
    a_obstacle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.obstacle) |-> ##4 (w_res_wr.valid
            && (w_res_wr.res.forward_cmd == '0) && (w_res_wr.res.turn_cmd == '0)))
        else $error("obstacle beat did not yield a zero result");

    // every result written to the queue lies within the turn limit
    a_turn_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_wr.valid |->
            (w_res_wr.res.turn_cmd <= $signed({1'b0, w_cfg.turn_limit}))
            && (w_res_wr.res.turn_cmd >= -$signed({1'b0, w_cfg.turn_limit})))
        else $error("turn command outside the turn limit");

endmodule

>>> verif/ptwi_turn_monitor.sv
// Channel monitor: predicts steering commands from accepted samples and compares them.
`timescale 1ns / 100ps

module ptwi_turn_monitor (
    input  logic i_clk,
    input  logic i_rst_n,
    ptwi_in_if   i_in,
    ptwi_out_if  i_out,
    ptwi_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_cmds_owed
);
    import ptwi_pkg::*;

    t_cfg                    regs;
    logic signed [ERR_W-1:0] err_window [RING_DEPTH];
    int unsigned             win_slot;
    logic signed [SUM_W-1:0] win_sum;
    logic signed [ERR_W-1:0] last_err;
    t_result                 cmd_expect_q [$];
    int                      fails = 0;

    initial begin
        o_fail_count = 0;
        o_cmds_owed  = 0;
    end

    // One sample in, one command out; obstacle beats leave the state alone.
    function automatic t_result steer(input logic [LVL_W-1:0] bright, input logic blocked);
        t_result                 cmd;
        logic signed [ERR_W-1:0] err;
        longint                  acc;
        longint                  turn;
        longint                  lim;
        cmd = '0;
        if (blocked)
            return cmd;
        err = $signed({1'b0, bright}) - $signed({1'b0, regs.target_level});
        win_sum = win_sum - err_window[win_slot] + err;
        err_window[win_slot] = err;
        win_slot = (win_slot + 1 == RING_DEPTH) ? 0 : win_slot + 1;
        acc = longint'(regs.prop_gain) * longint'(err)
            + longint'(regs.integ_gain_dt) * longint'(win_sum)
            + longint'(regs.deriv_gain_dt) * (longint'(err) - longint'(last_err));
        last_err = err;
        turn = acc / (longint'(1) << FRAC_BITS);
        lim  = longint'(regs.turn_limit);
        if (turn > lim)
            turn = lim;
        else if (turn < -lim)
            turn = -lim;
        cmd.forward_cmd = regs.cruise_speed;
        cmd.turn_cmd    = TURN_W'(turn);
        return cmd;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            regs.target_level  = RST_TARGET_LEVEL;
            regs.prop_gain     = RST_PROP_GAIN;
            regs.integ_gain_dt = RST_INTEG_GAIN_DT;
            regs.deriv_gain_dt = RST_DERIV_GAIN_DT;
            regs.turn_limit    = RST_TURN_LIMIT;
            regs.cruise_speed  = RST_CRUISE_SPEED;
            foreach (err_window[k])
                err_window[k] = '0;
            win_slot = 0;
            win_sum  = '0;
            last_err = '0;
            cmd_expect_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_TARGET_LEVEL:  regs.target_level  = i_cfg.data[LVL_W-1:0];
                    REG_PROP_GAIN:     regs.prop_gain     = i_cfg.data;
                    REG_INTEG_GAIN_DT: regs.integ_gain_dt = i_cfg.data;
                    REG_DERIV_GAIN_DT: regs.deriv_gain_dt = i_cfg.data;
                    REG_TURN_LIMIT:    regs.turn_limit    = i_cfg.data[LVL_W-1:0];
                    REG_CRUISE_SPEED:  regs.cruise_speed  = i_cfg.data[LVL_W-1:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                cmd_expect_q.push_back(steer(i_in.brightness, i_in.obstacle));
            if (i_out.valid && i_out.ready) begin
                got.forward_cmd = i_out.forward_cmd;
                got.turn_cmd    = i_out.turn_cmd;
                if (cmd_expect_q.size() == 0) begin
                    fails++;
                    $display("%0t unexpected command beat: expected none, got fwd %0d turn %0d",
                             $time, got.forward_cmd, $signed(got.turn_cmd));
                end else begin
                    want = cmd_expect_q.pop_front();
                    if (got.forward_cmd !== want.forward_cmd) begin
                        fails++;
                        $display("%0t forward_cmd mismatch: expected %0d, got %0d",
                                 $time, want.forward_cmd, got.forward_cmd);
                    end
                    if (got.turn_cmd !== want.turn_cmd) begin
                        fails++;
                        $display("%0t turn_cmd mismatch: expected %0d, got %0d",
                                 $time, $signed(want.turn_cmd), $signed(got.turn_cmd));
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_cmds_owed  <= cmd_expect_q.size();
    end

endmodule

>>> verif/pid_turn_windowed_integral_core_test.sv
// Top of the steering core testbench: clock, reset, stimulus, output back-pressure, verdict.
`timescale 1ns / 100ps

module pid_turn_windowed_integral_core_test;
    import ptwi_pkg::*;

    // Longest run of cycles with no beat on any channel before the run is called hung.
    // The long output hold is shorter than it; random gaps end far sooner.
    localparam int QUIET_LIMIT  = 3000;
    localparam int LONG_HOLD    = 300;
    // Pipeline is five deep; give it a bit more before the verdict.
    localparam int DRAIN_CYCLES = 12;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_BEATS  = 222;

    // Register indexes past the end of the map: writes there must do nothing.
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = CFG_IDX_W'(REG_CRUISE_SPEED + 1);
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = '1;

    // Opening beats at reset settings, packed as {obstacle, brightness}:
    // zero error, both brightness extremes, values past 100, obstacles with
    // extreme samples (and a sample right after, which must see the held
    // previous error), and full-swing alternation for the largest derivative.
    localparam logic [LVL_W:0] OPENING [16] = '{
        {1'b0, 7'd35},  {1'b0, 7'd0},   {1'b0, 7'd127}, {1'b0, 7'd100},
        {1'b1, 7'd0},   {1'b1, 7'd127}, {1'b0, 7'd101}, {1'b0, 7'd35},
        {1'b0, 7'd0},   {1'b0, 7'd127}, {1'b0, 7'd0},   {1'b0, 7'd127},
        {1'b1, 7'd64},  {1'b0, 7'd64},  {1'b0, 7'd1},   {1'b0, 7'd126}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    // Idle/stall odds in percent; sender side read only by the stimulus process.
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    // Each flip asks the output side for one long hold.
    bit hold_toggle    = 1'b0;

    int fail_count;
    int cmds_owed;

    ptwi_in_if  sample_bus ();
    ptwi_out_if cmd_bus ();
    ptwi_cfg_if reg_bus ();

    pid_turn_windowed_integral_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sample_bus.sink),
        .o_out   (cmd_bus.source),
        .i_cfg   (reg_bus.sink)
    );

    ptwi_turn_monitor u_turn_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (sample_bus),
        .i_out        (cmd_bus),
        .i_cfg        (reg_bus),
        .o_fail_count (fail_count),
        .o_cmds_owed  (cmds_owed)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one sample beat, after a random number of idle cycles, and return
    // right after the edge that takes it. Valid stays high for the caller to
    // lower or reuse, so it never gets two updates in one step.
    task automatic send_sample(input logic [LVL_W-1:0] bright, input logic obst);
        while ($urandom_range(99) < src_idle_pct) begin
            sample_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_bus.valid      <= 1'b1;
        sample_bus.brightness <= bright;
        sample_bus.obstacle   <= obst;
        @(posedge i_clk);
        while (!sample_bus.ready)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        reg_bus.valid <= 1'b1;
        reg_bus.index <= idx;
        reg_bus.data  <= val;
        @(posedge i_clk);
        while (!reg_bus.ready)
            @(posedge i_clk);
    endtask

    // Stop offering samples and wait until every command owed has come out.
    // The owed count is registered in the monitor, so it lags the monitor's queue
    // and cannot show zero before the last beat is really gone.
    task automatic wait_idle();
        sample_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (cmds_owed != 0)
            @(posedge i_clk);
    endtask

    // Load a full register set. Narrow registers get random junk above their
    // width (it must be dropped); the spare-index write goes last so a decode
    // bug would stick.
    task automatic write_settings(input t_cfg s, input logic [CFG_IDX_W-1:0] spare_idx);
        write_reg(REG_TARGET_LEVEL,  {(CFG_DATA_W-LVL_W)'($urandom()), s.target_level});
        write_reg(REG_PROP_GAIN,     s.prop_gain);
        write_reg(REG_INTEG_GAIN_DT, s.integ_gain_dt);
        write_reg(REG_DERIV_GAIN_DT, s.deriv_gain_dt);
        write_reg(REG_TURN_LIMIT,    {(CFG_DATA_W-LVL_W)'($urandom()), s.turn_limit});
        write_reg(REG_CRUISE_SPEED,  {(CFG_DATA_W-LVL_W)'($urandom()), s.cruise_speed});
        write_reg(spare_idx, $urandom());
        reg_bus.valid <= 1'b0;
    endtask

    // Output side: random stalls at the current odds, plus a long hold on
    // request during which the input fills the core and gets throttled.
    initial begin
        int hold_left;
        bit hold_seen;
        hold_left     = 0;
        hold_seen     = 1'b0;
        cmd_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                cmd_bus.ready <= 1'b0;
            end else if (hold_left > 0) begin
                cmd_bus.ready <= 1'b0;
                hold_left--;
            end else if (hold_toggle != hold_seen) begin
                hold_seen = hold_toggle;
                hold_left = LONG_HOLD - 1;
                cmd_bus.ready <= 1'b0;
            end else begin
                cmd_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Hang detector: any beat on any channel restarts the count.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((sample_bus.valid && sample_bus.ready) || (cmd_bus.valid && cmd_bus.ready)
                    || (reg_bus.valid && reg_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_cfg             setting;
        logic [LVL_W-1:0] bright;
        logic             obst;
        int               pick;
        int               mode;

        i_rst_n               = 1'b0;
        sample_bus.valid      = 1'b0;
        sample_bus.brightness = '0;
        sample_bus.obstacle   = 1'b0;
        reg_bus.valid         = 1'b0;
        reg_bus.index         = '0;
        reg_bus.data          = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening at the reset register values, no idling.
        foreach (OPENING[k])
            send_sample(OPENING[k][LVL_W-1:0], OPENING[k][LVL_W]);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: setting = '{target_level: 7'd35, prop_gain: RST_PROP_GAIN,
                               integ_gain_dt: RST_INTEG_GAIN_DT,
                               deriv_gain_dt: RST_DERIV_GAIN_DT,
                               turn_limit: 7'd127, cruise_speed: 7'd100};
                // every gain at full scale: turn pinned to the rails, sign checked
                1: setting = '{target_level: 7'd100, prop_gain: '1, integ_gain_dt: '1,
                               deriv_gain_dt: '1, turn_limit: 7'd127, cruise_speed: 7'd127};
                // integral term alone, unsaturated: window sum / 128
                2: setting = '{target_level: 7'd64, prop_gain: '0,
                               integ_gain_dt: GAIN_W'(1) << 17, deriv_gain_dt: '0,
                               turn_limit: 7'd127, cruise_speed: 7'd1};
                // everything zero, limit zero
                3: setting = '{target_level: 7'd0, prop_gain: '0, integ_gain_dt: '0,
                               deriv_gain_dt: '0, turn_limit: 7'd0, cruise_speed: 7'd0};
                // unity P with small I and D, mostly inside the limit
                4: setting = '{target_level: 7'd50, prop_gain: GAIN_W'(1) << 24,
                               integ_gain_dt: GAIN_W'(1) << 12,
                               deriv_gain_dt: GAIN_W'(1) << 22,
                               turn_limit: 7'd127, cruise_speed: 7'd100};
                // top target, tight limit
                5: setting = '{target_level: 7'd127, prop_gain: '1, integ_gain_dt: '0,
                               deriv_gain_dt: '1, turn_limit: 7'd1, cruise_speed: 7'd45};
                default: begin
                    setting.target_level  = LVL_W'($urandom_range(127));
                    setting.prop_gain     = $urandom() >> $urandom_range(31);
                    setting.integ_gain_dt = $urandom() >> $urandom_range(31);
                    setting.deriv_gain_dt = $urandom() >> $urandom_range(31);
                    setting.turn_limit    = LVL_W'($urandom_range(127));
                    setting.cruise_speed  = LVL_W'($urandom_range(127));
                end
            endcase
            write_settings(setting, (p % 2 == 0) ? IDX_SPARE_LO : IDX_SPARE_HI);

            // Idle pattern rotates: none, sender gaps, output stalls, both light.
            mode = p % 4;
            src_idle_pct    = (mode == 1) ? 52 : (mode == 3) ? 14 : 0;
            sink_stall_pct <= (mode == 2) ? 52 : (mode == 3) ? 14 : 0;

            for (int n = 0; n < PHASE_BEATS; n++) begin
                // Long output hold while samples keep coming at full rate.
                if (p == 2 && n == 40)
                    hold_toggle <= ~hold_toggle;
                // Sender pause mid-phase until the core has fully drained.
                if (p == 5 && n == 110)
                    wait_idle();

                pick = $urandom_range(99);
                if (pick < 10)
                    bright = ($urandom_range(1) != 0) ? '1 : '0;
                else if (pick < 25)
                    bright = LVL_W'($urandom_range(127));
                else
                    bright = LVL_W'($urandom_range(100));
                obst = ($urandom_range(99) < 8);
                send_sample(bright, obst);
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
